// ===== rtl/core/stereo_audio_looper_assert.svh =====
// assertion helpers for the looper checker
`ifndef STEREO_AUDIO_LOOPER_ASSERT_SVH
`define STEREO_AUDIO_LOOPER_ASSERT_SVH

// same-cycle implication
`define SAL_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define SAL_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/sal_pkg.sv =====
package sal_pkg;

	localparam int SMP_W     = 24;
	localparam int FADE_W    = 13;
	localparam int LEN_W     = 21;
	localparam int OP_W      = 3;
	localparam int CFG_IDX_W = 2;

	localparam int unsigned DEF_MAX_FRAMES = 1048576;

	localparam logic [FADE_W-1:0] FADE_RST = 13'd96;
	localparam logic [LEN_W-1:0]  MAXF_RST = 21'd1048576;

	typedef enum logic [OP_W-1:0] {
		OP_FRAME,
		OP_PLAY,
		OP_STOP,
		OP_OVERDUB,
		OP_CLEAR,
		OP_REWIND
	} op_t;

	typedef enum logic [1:0] {
		MODE_STOP,
		MODE_REC,
		MODE_PLAY,
		MODE_OVD
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FADE_LEN,
		CFG_MAX_FRAMES
	} cfg_idx_t;

	typedef struct packed {
		logic              start;
		logic [FADE_W-1:0] num;
		logic [FADE_W-1:0] den;
	} gain_req_t;

endpackage

// ===== rtl/core/sal_ram.sv =====
module sal_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/sal_gain.sv =====
module sal_gain import sal_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gain_req_t               req,
	input  logic signed [SMP_W-1:0] in_l,
	input  logic signed [SMP_W-1:0] in_r,
	output logic                    done,
	output logic signed [SMP_W-1:0] out_l,
	output logic signed [SMP_W-1:0] out_r
);

	localparam int PROD_W = SMP_W + FADE_W;
	localparam int CNT_W  = $clog2(SMP_W);

	typedef enum logic [1:0] {
		G_IDLE,
		G_MUL_L,
		G_MUL_R,
		G_DIV
	} gstate_t;

	gstate_t            gst_q;
	logic               done_q;
	logic               neg_l_q, neg_r_q;
	logic [SMP_W-1:0]   mag_l_q, mag_r_q;
	logic [FADE_W-1:0]  num_q, den_q;
	logic [FADE_W-1:0]  rem_l_q, rem_r_q;
	logic [SMP_W-1:0]   lo_l_q, lo_r_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [SMP_W-1:0]   mul_a;
	logic [PROD_W-1:0]  prod;
	logic [FADE_W:0]    t_l, t_r;
	logic               ge_l, ge_r;
	logic [FADE_W-1:0]  nrem_l, nrem_r;

	assign mul_a = (gst_q == G_MUL_R) ? mag_r_q : mag_l_q;
	assign prod  = PROD_W'(mul_a) * PROD_W'(num_q);

	always_comb begin
		t_l    = {rem_l_q, lo_l_q[SMP_W-1]};
		t_r    = {rem_r_q, lo_r_q[SMP_W-1]};
		ge_l   = t_l >= {1'b0, den_q};
		ge_r   = t_r >= {1'b0, den_q};
		nrem_l = ge_l ? FADE_W'(t_l - {1'b0, den_q}) : t_l[FADE_W-1:0];
		nrem_r = ge_r ? FADE_W'(t_r - {1'b0, den_q}) : t_r[FADE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gst_q  <= G_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (gst_q)
				G_IDLE: begin
					if (req.start) begin
						neg_l_q <= in_l[SMP_W-1];
						neg_r_q <= in_r[SMP_W-1];
						mag_l_q <= in_l[SMP_W-1] ? SMP_W'(-in_l) : SMP_W'(in_l);
						mag_r_q <= in_r[SMP_W-1] ? SMP_W'(-in_r) : SMP_W'(in_r);
						num_q   <= req.num;
						den_q   <= req.den;
						gst_q   <= G_MUL_L;
					end
				end
				G_MUL_L: begin
					rem_l_q <= prod[PROD_W-1:SMP_W];
					lo_l_q  <= prod[SMP_W-1:0];
					gst_q   <= G_MUL_R;
				end
				G_MUL_R: begin
					rem_r_q <= prod[PROD_W-1:SMP_W];
					lo_r_q  <= prod[SMP_W-1:0];
					cnt_q   <= CNT_W'(SMP_W - 1);
					gst_q   <= G_DIV;
				end
				G_DIV: begin
					rem_l_q <= nrem_l;
					rem_r_q <= nrem_r;
					lo_l_q  <= {lo_l_q[SMP_W-2:0], ge_l};
					lo_r_q  <= {lo_r_q[SMP_W-2:0], ge_r};
					if (cnt_q == '0) begin
						done_q <= 1'b1;
						gst_q  <= G_IDLE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				default: gst_q <= G_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign out_l = neg_l_q ? -$signed(lo_l_q) : $signed(lo_l_q);
	assign out_r = neg_r_q ? -$signed(lo_r_q) : $signed(lo_r_q);

endmodule

// ===== rtl/core/stereo_audio_looper.sv =====
// Stereo looper with record, play, overdub, clear and rewind.
// Input channel (in_valid/in_ready) carries one word per audio frame or
// command: opcode plus a signed 24-bit left/right frame. Output channel
// (out_valid/out_ready) returns exactly one word per input word: the faded
// playback frame, mode, loop length and frames remaining.
// Configuration: cfg_we with cfg_idx 0 sets fade_len, 1 sets max_frames;
// write only while the block is idle.
// Commands pass EXEC and DONE between acceptance and out_valid. A recorded
// frame passes EXEC, and LOAD as well when it adds onto existing content; an
// unfaded played frame passes EXEC, LOAD and WB; a frame inside a fade
// region also waits in WAIT for the shared gain unit: one multiplier used
// twice, then a 24-step restoring divider by fade_len for both channels.
// One word is in flight at a time; in_ready is high only between words, so
// in_ready rises together with out_valid.
// The output register lets the next word be accepted while a result waits.
// Reset clears mode, position, length and content and restores the
// register defaults; sample memories are not cleared, no pass is needed.
// A stalled receiver holds the result; the block then waits in its last
// step until the result is taken.
module stereo_audio_looper import sal_pkg::*; #(
	parameter int unsigned MAX_FRAMES = DEF_MAX_FRAMES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         opcode,
	input  logic signed [SMP_W-1:0] in_left,
	input  logic signed [SMP_W-1:0] in_right,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SMP_W-1:0] out_left,
	output logic signed [SMP_W-1:0] out_right,
	output logic [1:0]              mode,
	output logic [LEN_W-1:0]        length_frames,
	output logic [LEN_W-1:0]        remaining_frames,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [LEN_W-1:0]        cfg_data
);

	localparam int AW = $clog2(MAX_FRAMES);
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int OW = (CW > LEN_W) ? CW : LEN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_WAIT,
		ST_WB,
		ST_DONE
	} state_t;

	function automatic logic signed [SMP_W-1:0] sat_add(
		input logic signed [SMP_W-1:0] a,
		input logic signed [SMP_W-1:0] b
	);
		logic signed [SMP_W:0] s;
		s = $signed({a[SMP_W-1], a}) + $signed({b[SMP_W-1], b});
		if (s[SMP_W] != s[SMP_W-1]) begin
			return s[SMP_W] ? $signed({1'b1, {(SMP_W-1){1'b0}}})
			                : $signed({1'b0, {(SMP_W-1){1'b1}}});
		end
		return s[SMP_W-1:0];
	endfunction

	state_t                  state_q;
	mode_t                   mode_q;
	logic [CW-1:0]           pos_q, len_q;
	logic                    content_q;
	logic [FADE_W-1:0]       fade_q;
	logic [LEN_W-1:0]        maxf_q;
	logic [OP_W-1:0]         op_q;
	logic signed [SMP_W-1:0] il_q, ir_q;
	logic signed [SMP_W-1:0] st_l_q, st_r_q;
	logic signed [SMP_W-1:0] res_l_q, res_r_q;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_left_q, out_right_q;
	logic [1:0]              mode_out_q;
	logic [LEN_W-1:0]        len_out_q, rem_out_q;

	logic [CW-1:0]           wrap_pos;
	logic [OW-1:0]           pos_ext, fade_ext, tail_ext, len_ext, rem_ext;
	logic                    at_limit, use_head, use_tail, unity;
	logic [CW-1:0]           rem_c;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic signed [SMP_W-1:0] wdata_l, wdata_r;
	logic [SMP_W-1:0]        rd_l, rd_r;

	gain_req_t               greq;
	logic                    gain_done;
	logic signed [SMP_W-1:0] gain_l, gain_r;

	assign wrap_pos = (pos_q >= len_q) ? '0 : pos_q;
	assign pos_ext  = OW'(pos_q);
	assign fade_ext = OW'(fade_q);
	assign tail_ext = OW'(len_q - pos_q - CW'(1));
	assign at_limit = (pos_ext >= OW'(maxf_q)) || (pos_ext >= OW'(MAX_FRAMES));
	assign use_head = (fade_q != '0) && (pos_ext < fade_ext);
	assign use_tail = (fade_q != '0) && (tail_ext < fade_ext);
	assign unity    = !use_head && !use_tail;

	assign greq.start = (state_q == ST_LOAD) && (mode_q != MODE_REC) && !unity;
	assign greq.num   = use_head ? pos_ext[FADE_W-1:0] : tail_ext[FADE_W-1:0];
	assign greq.den   = fade_q;

	assign rem_c   = ((mode_q == MODE_PLAY) && (pos_q <= len_q)) ? (len_q - pos_q) : '0;
	assign rem_ext = OW'(rem_c);
	assign len_ext = OW'(len_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		wdata_l   = il_q;
		wdata_r   = ir_q;
		unique case (state_q)
			ST_EXEC: begin
				mem_we = (op_q == OP_FRAME) && (mode_q == MODE_REC) && !at_limit
				         && (pos_q >= len_q);
			end
			ST_LOAD: begin
				if (mode_q == MODE_REC) begin
					mem_we  = 1'b1;
					wdata_l = sat_add($signed(rd_l), il_q);
					wdata_r = sat_add($signed(rd_r), ir_q);
				end
			end
			ST_WB: begin
				if (mode_q == MODE_OVD && !at_limit) begin
					mem_we  = 1'b1;
					wdata_l = sat_add(st_l_q, il_q);
					wdata_r = sat_add(st_r_q, ir_q);
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	sal_ram #(
		.WIDTH(SMP_W),
		.DEPTH(MAX_FRAMES)
	) u_ram_l (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(wdata_l),
		.raddr(wrap_pos[AW-1:0]),
		.rdata(rd_l)
	);

	sal_ram #(
		.WIDTH(SMP_W),
		.DEPTH(MAX_FRAMES)
	) u_ram_r (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(wdata_r),
		.raddr(wrap_pos[AW-1:0]),
		.rdata(rd_r)
	);

	sal_gain u_gain (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (greq),
		.in_l  ($signed(rd_l)),
		.in_r  ($signed(rd_r)),
		.done  (gain_done),
		.out_l (gain_l),
		.out_r (gain_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_STOP;
			pos_q       <= '0;
			len_q       <= '0;
			content_q   <= 1'b0;
			fade_q      <= FADE_RST;
			maxf_q      <= MAXF_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_FADE_LEN:   fade_q <= cfg_data[FADE_W-1:0];
					CFG_MAX_FRAMES: maxf_q <= cfg_data;
					default:        ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						il_q    <= in_left;
						ir_q    <= in_right;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_l_q <= '0;
					res_r_q <= '0;
					state_q <= ST_DONE;
					unique case (op_q)
						OP_FRAME: begin
							case (mode_q) inside
								MODE_REC: begin
									if (at_limit) begin
										mode_q <= MODE_STOP;
									end else if (pos_q < len_q) begin
										state_q <= ST_LOAD;
									end else begin
										len_q     <= pos_q + CW'(1);
										content_q <= 1'b1;
										pos_q     <= pos_q + CW'(1);
									end
								end
								MODE_PLAY, MODE_OVD: begin
									if (!content_q || len_q == '0) begin
										mode_q <= MODE_STOP;
									end else begin
										pos_q   <= wrap_pos;
										state_q <= ST_LOAD;
									end
								end
								default: ;
							endcase
						end
						OP_PLAY: begin
							mode_q <= content_q ? MODE_PLAY : MODE_REC;
							pos_q  <= '0;
						end
						OP_STOP: mode_q <= MODE_STOP;
						OP_OVERDUB: begin
							mode_q <= (content_q && len_q != '0) ? MODE_OVD : MODE_STOP;
						end
						OP_CLEAR: begin
							content_q <= 1'b0;
							mode_q    <= MODE_STOP;
							len_q     <= '0;
							pos_q     <= '0;
						end
						OP_REWIND: pos_q <= '0;
						default: ;
					endcase
				end
				ST_LOAD: begin
					if (mode_q == MODE_REC) begin
						content_q <= 1'b1;
						pos_q     <= pos_q + CW'(1);
						state_q   <= ST_DONE;
					end else begin
						st_l_q <= $signed(rd_l);
						st_r_q <= $signed(rd_r);
						if (unity) begin
							res_l_q <= $signed(rd_l);
							res_r_q <= $signed(rd_r);
							state_q <= ST_WB;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (gain_done) begin
						res_l_q <= gain_l;
						res_r_q <= gain_r;
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (mode_q == MODE_OVD && at_limit) begin
						mode_q <= MODE_STOP;
					end
					pos_q   <= pos_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_left_q  <= res_l_q;
						out_right_q <= res_r_q;
						mode_out_q  <= mode_q;
						len_out_q   <= len_ext[LEN_W-1:0];
						rem_out_q   <= rem_ext[LEN_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready         = (state_q == ST_IDLE);
	assign out_valid        = out_valid_q;
	assign out_left         = out_left_q;
	assign out_right        = out_right_q;
	assign mode             = mode_out_q;
	assign length_frames    = len_out_q;
	assign remaining_frames = rem_out_q;

endmodule

// ===== rtl/core/sal_check.sv =====
`include "stereo_audio_looper_assert.svh"

module sal_check import sal_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [SMP_W-1:0] out_left,
	input logic signed [SMP_W-1:0] out_right,
	input logic [1:0]              mode,
	input logic [LEN_W-1:0]        remaining_frames
);

	`SAL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "in_ready high after accept")
	`SAL_ASSERT_IMP(a_rem_only_playing, out_valid && (mode != MODE_PLAY), remaining_frames == '0, "remaining frames outside play")
	`SAL_ASSERT_IMP(a_rec_silent, out_valid && (mode == MODE_REC), (out_left == '0) && (out_right == '0), "output not silent while recording")
	`SAL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left) && $stable(mode), "stalled word changed")

endmodule

bind stereo_audio_looper sal_check u_sal_check (.*);

// ===== tb/sv/tb_stereo_audio_looper.sv =====
`timescale 1ns / 1ps

module tb_stereo_audio_looper;
	import sal_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_WORDS = 80;

	localparam logic signed [SMP_W-1:0] S_MAX = 24'sh7fffff;
	localparam logic signed [SMP_W-1:0] S_MIN = 24'sh800000;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic signed [SMP_W-1:0] l;
		logic signed [SMP_W-1:0] r;
	} loop_word_t;

	typedef struct {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
		mode_t                   md;
		logic [LEN_W-1:0]        len;
		logic [LEN_W-1:0]        rem;
	} playback_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         opcode = '0;
	logic signed [SMP_W-1:0] in_left = '0;
	logic signed [SMP_W-1:0] in_right = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [SMP_W-1:0] out_left;
	logic signed [SMP_W-1:0] out_right;
	logic [1:0]              mode;
	logic [LEN_W-1:0]        length_frames;
	logic [LEN_W-1:0]        remaining_frames;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_idx = '0;
	logic [LEN_W-1:0]        cfg_data = '0;

	stereo_audio_looper dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// looper state as seen from outside
	int          left_mem[int];
	int          right_mem[int];
	int unsigned play_pos = 0;
	int unsigned loop_len = 0;
	bit          has_content = 1'b0;
	mode_t       cur_mode = MODE_STOP;
	int unsigned fade_cfg = 96;
	int unsigned maxf_cfg = 1048576;

	loop_word_t pending_words[$];
	playback_t  expected_playback[$];
	loop_word_t next_word;
	int         words_added = 0;
	int         errors = 0;
	int         results_seen = 0;
	int         gap_left = 0;
	int         calm_in = 0;
	int         stall_left = 0;
	int         calm_out = 0;
	int         hold_left = 0;
	int         quiet_cycles = 0;

	function automatic int sat24(longint v);
		if (v > longint'(S_MAX))
			return int'(S_MAX);
		if (v < longint'(S_MIN))
			return int'(S_MIN);
		return int'(v);
	endfunction

	// linear fade-in over the first frames, fade-out over the last
	function automatic int faded(int s, int unsigned p);
		int unsigned tail;
		tail = loop_len - 1 - p;
		if (fade_cfg != 0 && p < fade_cfg)
			return int'(longint'(s) * longint'(p) / longint'(fade_cfg));
		if (fade_cfg != 0 && tail < fade_cfg)
			return int'(longint'(s) * longint'(tail) / longint'(fade_cfg));
		return s;
	endfunction

	task automatic loop_step(input logic [OP_W-1:0] op, input int il, input int ir);
		int unsigned p;
		int unsigned lim;
		int          ol;
		int          orr;
		playback_t   res;
		ol = 0;
		orr = 0;
		lim = (maxf_cfg < DEF_MAX_FRAMES) ? maxf_cfg : DEF_MAX_FRAMES;
		case (op)
			OP_FRAME: begin
				p = play_pos;
				if (cur_mode == MODE_REC) begin
					if (p >= lim) begin
						cur_mode = MODE_STOP;
					end else begin
						if (p < loop_len) begin
							left_mem[p] = sat24(longint'(left_mem[p]) + il);
							right_mem[p] = sat24(longint'(right_mem[p]) + ir);
						end else begin
							left_mem[p] = il;
							right_mem[p] = ir;
							loop_len = p + 1;
						end
						has_content = 1'b1;
						play_pos = p + 1;
					end
				end else if (cur_mode == MODE_PLAY || cur_mode == MODE_OVD) begin
					if (!has_content || loop_len == 0) begin
						cur_mode = MODE_STOP;
					end else begin
						if (play_pos >= loop_len)
							play_pos = 0;
						p = play_pos;
						ol = faded(left_mem[p], p);
						orr = faded(right_mem[p], p);
						if (cur_mode == MODE_OVD) begin
							if (p >= lim) begin
								cur_mode = MODE_STOP;
							end else begin
								left_mem[p] = sat24(longint'(left_mem[p]) + il);
								right_mem[p] = sat24(longint'(right_mem[p]) + ir);
							end
						end
						play_pos = p + 1;
					end
				end
			end
			OP_PLAY: begin
				cur_mode = has_content ? MODE_PLAY : MODE_REC;
				play_pos = 0;
			end
			OP_STOP: begin
				cur_mode = MODE_STOP;
			end
			OP_OVERDUB: begin
				cur_mode = (has_content && loop_len != 0) ? MODE_OVD : MODE_STOP;
			end
			OP_CLEAR: begin
				left_mem.delete();
				right_mem.delete();
				has_content = 1'b0;
				cur_mode = MODE_STOP;
				loop_len = 0;
				play_pos = 0;
			end
			OP_REWIND: begin
				play_pos = 0;
			end
			default: ;
		endcase
		res.left = ol[SMP_W-1:0];
		res.right = orr[SMP_W-1:0];
		res.md = cur_mode;
		res.len = loop_len[LEN_W-1:0];
		res.rem = (cur_mode == MODE_PLAY && play_pos <= loop_len) ?
			LEN_W'(loop_len - play_pos) : '0;
		expected_playback.push_back(res);
	endtask

	// mostly short gaps, a few long ones, now and then a stretch with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r == 0) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (r < 100)
			return 0;
		if (r < 170)
			return $urandom_range(1, 3);
		if (r < 194)
			return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	function automatic logic signed [SMP_W-1:0] rnd_smp();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			default: return SMP_W'($urandom_range(0, 24'hffffff));
		endcase
	endfunction

	task automatic add_word(input logic [OP_W-1:0] op, input logic signed [SMP_W-1:0] l,
			input logic signed [SMP_W-1:0] r);
		loop_word_t w;
		w.op = op;
		w.l = l;
		w.r = r;
		pending_words.push_back(w);
		words_added++;
	endtask

	task automatic add_cmd(input logic [OP_W-1:0] op);
		add_word(op, rnd_smp(), rnd_smp());
	endtask

	task automatic add_frames(input int n);
		repeat (n) add_word(OP_FRAME, rnd_smp(), rnd_smp());
	endtask

	// record / play / overdub sessions with random content, plus some noise
	task automatic gen_phase(input int budget);
		int stop_at;
		stop_at = words_added + budget;
		while (words_added < stop_at) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					add_cmd(OP_CLEAR);
					add_cmd(OP_PLAY);
				end
				2: add_cmd(OP_PLAY);
				default: add_cmd(OP_OVERDUB);
			endcase
			add_frames($urandom_range(1, 30));
			if ($urandom_range(0, 2) == 0) begin
				add_cmd(OP_REWIND);
				add_frames($urandom_range(1, 8));
			end
			add_cmd(($urandom_range(0, 1) != 0) ? OP_PLAY : OP_STOP);
			add_cmd(OP_PLAY);
			add_frames($urandom_range(1, 30));
			add_cmd(OP_OVERDUB);
			add_frames($urandom_range(1, 20));
			if ($urandom_range(0, 3) == 0)
				add_cmd(OP_STOP);
			repeat ($urandom_range(0, 3))
				add_word(OP_W'($urandom_range(OP_FRAME, OP_RSVD7)), rnd_smp(), rnd_smp());
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [LEN_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		if (idx == CFG_FADE_LEN)
			fade_cfg = 32'(v & 21'h1fff);
		else
			maxf_cfg = 32'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_playback.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_phase(input logic [LEN_W-1:0] fade, input logic [LEN_W-1:0] maxf);
		write_reg(CFG_FADE_LEN, fade);
		write_reg(CFG_MAX_FRAMES, maxf);
		gen_phase(PHASE_WORDS);
		drain();
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
			calm_in = 0;
		end else begin
			if (in_valid && in_ready)
				loop_step(opcode, int'(in_left), int'(in_right));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					next_word = pending_words.pop_front();
					opcode <= next_word.op;
					in_left <= next_word.l;
					in_right <= next_word.r;
					in_valid <= 1'b1;
					gap_left = pick_gap(calm_in);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		playback_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			calm_out = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_playback.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					e = expected_playback.pop_front();
					if (out_left !== e.left) begin
						$error("out_left: expected %0d, got %0d", e.left, out_left);
						errors++;
					end
					if (out_right !== e.right) begin
						$error("out_right: expected %0d, got %0d", e.right, out_right);
						errors++;
					end
					if (mode !== e.md) begin
						$error("mode: expected %0d, got %0d", e.md, mode);
						errors++;
					end
					if (length_frames !== e.len) begin
						$error("length_frames: expected %0d, got %0d", e.len, length_frames);
						errors++;
					end
					if (remaining_frames !== e.rem) begin
						$error("remaining_frames: expected %0d, got %0d", e.rem,
							remaining_frames);
						errors++;
					end
				end
				results_seen++;
				// long hold-off so the block backs up into its input
				if (results_seen == 30 || results_seen == 350)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				stall_left = pick_gap(calm_out);
				out_ready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_stereo_audio_looper: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		add_word(OP_FRAME, S_MAX, S_MIN);
		add_cmd(OP_OVERDUB);
		add_cmd(OP_RSVD6);
		add_cmd(OP_RSVD7);
		add_cmd(OP_REWIND);
		add_cmd(OP_PLAY);
		add_word(OP_FRAME, S_MAX, S_MIN);
		add_word(OP_FRAME, S_MIN, S_MAX);
		add_word(OP_FRAME, '0, -24'sd1);
		add_word(OP_FRAME, -24'sd1, '0);
		add_word(OP_FRAME, S_MAX, S_MAX);
		add_cmd(OP_REWIND);
		add_word(OP_FRAME, S_MAX, S_MAX);
		add_word(OP_FRAME, S_MIN, S_MIN);
		add_cmd(OP_STOP);
		add_cmd(OP_PLAY);
		add_frames(3);
		add_cmd(OP_OVERDUB);
		add_frames(3);
		add_cmd(OP_CLEAR);
		add_frames(1);
		drain();

		run_phase(3, 40);
		run_phase(0, 1);
		run_phase(1, 17);
		run_phase(4096, 64);
		run_phase(8191, 21'h1fffff);
		run_phase(12, 1048576);

		if (errors == 0)
			$display("tb_stereo_audio_looper: done, clean");
		else
			$display("tb_stereo_audio_looper: done, errors");
		$finish;
	end

endmodule
